FILE: src/cascaded_angle_velocity_pid_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded angle/velocity PID unit.
// ----------------------------------------------------------------------------
`ifndef CASCADED_ANGLE_VELOCITY_PID_UNIT_DEFINES_SVH
`define CASCADED_ANGLE_VELOCITY_PID_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CAVP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAVP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cavp_pkg.sv
// ----------------------------------------------------------------------------
// cavp_pkg
// Widths, constants and shared types of the cascaded angle/velocity PID unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cavp_pkg;

   // Field and datapath widths.
   localparam int RAW_W   = 13;
   localparam int VEL_W   = 16;
   localparam int TGT_W   = 24;
   localparam int DRV_W   = 16;
   localparam int DEG_W   = 9;
   localparam int MULTI_W = 32;
   localparam int CAND_W  = 26;
   localparam int DIFF_W  = 34;
   localparam int OFF_W   = 22;
   localparam int PNOW_W  = 53;
   localparam int SPD_W   = 24;
   localparam int VERR_W  = 25;
   localparam int INT_W   = 25;
   localparam int MA_W    = 35;
   localparam int MB_W    = 31;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int DVD_W   = 49;
   localparam int DVS_W   = 16;
   localparam int STEP_W  = 6;

   // Algorithm constants, angles in 1/256 degree.
   localparam int NEAR_BAND      = 100 * 256;
   localparam int HALF_TURN      = 180 * 256;
   localparam int ALIAS_STEPS    = 50;

   // Division by five as a reciprocal product, exact for dividends below 2^30.
   localparam int RECIP5         = 858993460;
   localparam int RECIP5_SHIFT   = 32;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_ANGLE_KP        = 3'd0,
      REG_ANGLE_OUTLIMIT  = 3'd1,
      REG_ANGLE_SLOW_ZONE = 3'd2,
      REG_VEL_KP          = 3'd3,
      REG_VEL_KI          = 3'd4,
      REG_VEL_KD          = 3'd5,
      REG_VEL_I_WINDOW    = 3'd6,
      REG_VEL_LIMITS      = 3'd7
   } csr_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_ALIAS  = 18'h00002,
      ST_TRACK  = 18'h00004,
      ST_ERR    = 18'h00008,
      ST_PMUL   = 18'h00010,
      ST_PNOW   = 18'h00020,
      ST_SCALE  = 18'h00040,
      ST_SMUL   = 18'h00080,
      ST_SDIV   = 18'h00100,
      ST_CLAMP  = 18'h00200,
      ST_VERR   = 18'h00400,
      ST_VMUL_P = 18'h00800,
      ST_VMUL_I = 18'h01000,
      ST_VMUL_D = 18'h02000,
      ST_VCAP   = 18'h04000,
      ST_INTEG  = 18'h08000,
      ST_DRIVE  = 18'h10000,
      ST_FIN    = 18'h20000
   } state_type;

   // Divider status back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

FILE: src/cavp_mul.sv
// ----------------------------------------------------------------------------
// cavp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module cavp_mul (
   input  logic                                clock,
   input  logic signed [cavp_pkg::MA_W-1:0]   mul_a,
   input  logic signed [cavp_pkg::MB_W-1:0]   mul_b,
   output logic signed [cavp_pkg::PROD_W-1:0] prod
);
   import cavp_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // One product per cycle, available the cycle after the operands.
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: src/cavp_div.sv
// ----------------------------------------------------------------------------
// cavp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cavp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [cavp_pkg::DVD_W-1:0]       dividend,
   input  logic [cavp_pkg::DVS_W-1:0]       divisor,
   output logic [cavp_pkg::DVD_W-1:0]       quotient,
   output cavp_pkg::div_status_type          status
);
   import cavp_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   // Trial subtraction of the divisor from the shifted remainder.
   assign trial = {rem_ff, quo_ff[DVD_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

FILE: src/cascaded_angle_velocity_pid_unit.sv
// ----------------------------------------------------------------------------
// cascaded_angle_velocity_pid_unit
// Cascaded angle/velocity PID for several motor channels with shared gains.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tuser: motor_index; tdata: angle raw, velocity, target
// rsp      out        tdata: drive_value, reverse_direction
// csr      in         write enable, register index, 32-bit write data
//
// Each item runs the alias search for 1 to 50 steps. Inside the slow zone
// the gain floor adds a reciprocal multiply, and the ramp adds a multiply and
// the 49-step divider. An item for a channel out of range goes straight from
// idle to the last state and returns a zero drive with the reverse flag clear.
// req_tready is high only while the sequencer is idle. A finished item waits
// in the output register while the next item is accepted; the sequencer
// stalls in its last state while that register is still full. Reset is
// synchronous and clears all channel state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascaded_angle_velocity_pid_unit_defines.svh"

module cascaded_angle_velocity_pid_unit #(
   parameter int NUM_MOTORS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [12:0] feedback_angle_raw, [28:13] feedback_velocity, [52:29] target_angle
   input  logic [55:0] req_tdata,
   // [1:0] motor_index
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] drive_value, [16] reverse_direction
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cavp_pkg::*;

   localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   // Configuration registers.
   logic [23:0] angle_kp_ff, vel_kp_ff, vel_ki_ff, vel_kd_ff;
   logic [22:0] angle_outlimit_ff;
   logic [15:0] angle_slow_zone_ff;
   logic [31:0] vel_i_window_ff, vel_limits_ff;

   // Channel state.
   logic signed [MULTI_W-1:0] multi_ff    [NUM_MOTORS];
   logic        [DEG_W-1:0]   prev_ang_ff [NUM_MOTORS];
   logic signed [VEL_W-1:0]   prev_vel_ff [NUM_MOTORS];
   logic signed [INT_W-1:0]   integ_ff    [NUM_MOTORS];

   // Sequencer and item registers.
   state_type                state_ff;
   logic [1:0]               ch_ff;
   logic [RAW_W-1:0]         raw_ff;
   logic signed [VEL_W-1:0]  vel_ff;
   logic signed [TGT_W-1:0]  tgt_ff;
   logic signed [CAND_W-1:0] cand_ff;
   logic [OFF_W-1:0]         off_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     last_ff;
   logic signed [DIFF_W-1:0] err_ff;
   logic [DIFF_W-1:0]        aerr_ff;
   logic signed [PNOW_W-1:0] pnow_ff;
   logic signed [PNOW_W-1:0] spd_raw_ff;
   logic                     neg_ff;
   logic signed [SPD_W-1:0]  spd_ff;
   logic signed [VERR_W-1:0] verr_ff;
   logic [VERR_W-1:0]        averr_ff;
   logic signed [40:0]       p_ff, i_ff, d_ff;
   logic signed [INT_W-1:0]  itot_ff;
   logic signed [24:0]       drv_ff;
   logic                     rsp_valid_ff;
   logic [DRV_W-1:0]         rsp_drive_ff;
   logic                     rsp_rev_ff;

   // Shared units.
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     div_start;
   logic [DVD_W-1:0]         div_dividend, div_quotient;
   logic [DVS_W-1:0]         div_divisor;
   div_status_type           div_stat;

   logic                     accept;
   logic                     in_range;
   logic [IDX_W-1:0]         slot;
   logic signed [MULTI_W-1:0] multi_cur;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign in_range   = int'(req_tuser) < NUM_MOTORS;
   assign slot       = IDX_W'(ch_ff);
   assign multi_cur  = multi_ff[slot];

   // Alias search step.
   logic signed [DIFF_W-1:0] alias_dd;
   logic                     alias_near;
   logic signed [CAND_W-1:0] off_s, cand_next;

   assign alias_dd   = DIFF_W'(cand_ff) - DIFF_W'(multi_cur);
   assign alias_near = (alias_dd < $signed(DIFF_W'(NEAR_BAND))) &&
                       (alias_dd > -$signed(DIFF_W'(NEAR_BAND)));
   assign off_s      = $signed({{(CAND_W-OFF_W){1'b0}}, off_ff});
   assign cand_next  = (alias_dd < 0) ? (CAND_W'(tgt_ff) + off_s)
                                      : (CAND_W'(tgt_ff) - off_s);

   // Multi-turn tracking with wrap correction and saturation.
   logic [21:0]        deg_prod;
   logic [DEG_W-1:0]   deg;
   logic signed [10:0] ang_diff, ang_wrap;
   logic signed [33:0] msum;
   logic signed [MULTI_W-1:0] multi_new;

   assign deg_prod = 22'(raw_ff) * 22'(360);
   assign deg      = deg_prod[21:13];
   assign ang_diff = $signed({2'b00, deg}) - $signed({2'b00, prev_ang_ff[slot]});

   always_comb begin
      ang_wrap = ang_diff;
      if (ang_diff < -11'sd180) begin
         ang_wrap = ang_diff + 11'sd360;
      end else if (ang_diff > 11'sd180) begin
         ang_wrap = ang_diff - 11'sd360;
      end
   end

   assign msum = 34'(multi_cur) + 34'($signed({ang_wrap, 8'b0}));

   always_comb begin
      if (msum[33:31] == 3'b000 || msum[33:31] == 3'b111) begin
         multi_new = msum[31:0];
      end else if (msum[33]) begin
         multi_new = $signed({1'b1, {(MULTI_W-1){1'b0}}});
      end else begin
         multi_new = $signed({1'b0, {(MULTI_W-1){1'b1}}});
      end
   end

   // Slow zone decisions.
   logic        in_zone, gain_floor;
   logic [35:0] aerr5;

   assign aerr5      = {2'b00, aerr_ff} + {aerr_ff, 2'b00};
   assign in_zone    = aerr_ff < DIFF_W'(angle_slow_zone_ff);
   assign gain_floor = aerr5 < 36'(angle_slow_zone_ff);

   // Magnitudes for the divider and the reciprocal product.
   logic signed [PNOW_W-1:0] pnow_abs;
   logic signed [PROD_W-1:0] prod_abs;
   logic [29:0]              fifth_q;

   assign pnow_abs = (pnow_ff < 0) ? -pnow_ff : pnow_ff;
   assign prod_abs = (prod < 0) ? -prod : prod;
   assign fifth_q  = prod[RECIP5_SHIFT+29:RECIP5_SHIFT];

   assign div_start    = (state_ff == ST_SMUL) && !gain_floor;
   assign div_dividend = prod_abs[DVD_W-1:0];
   assign div_divisor  = angle_slow_zone_ff;

   // Speed target clamp and velocity error.
   logic signed [PNOW_W-1:0] lim_s;
   logic signed [SPD_W-1:0]  spd_next;
   logic signed [VERR_W-1:0] verr_next;
   logic signed [VEL_W:0]    vel_diff;

   assign lim_s = $signed({{(PNOW_W-23){1'b0}}, angle_outlimit_ff});

   always_comb begin
      if (spd_raw_ff > lim_s) begin
         spd_next = SPD_W'(lim_s);
      end else if (spd_raw_ff < -lim_s) begin
         spd_next = SPD_W'(-lim_s);
      end else begin
         spd_next = SPD_W'(spd_raw_ff);
      end
   end

   assign verr_next = VERR_W'(spd_ff) - VERR_W'($signed({vel_ff, 8'b0}));
   assign vel_diff  = (VEL_W+1)'(prev_vel_ff[slot]) - (VEL_W+1)'(vel_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_PMUL: begin
            mul_a = MA_W'(err_ff);
            mul_b = $signed({7'b0, angle_kp_ff});
         end
         ST_SCALE: begin
            // Gain floor divides by five through the reciprocal.
            if (gain_floor) begin
               mul_a = MA_W'(RECIP5);
               mul_b = $signed({1'b0, pnow_abs[29:0]});
            end else begin
               mul_a = pnow_ff[MA_W-1:0];
               mul_b = $signed({15'b0, aerr_ff[15:0]});
            end
         end
         ST_VMUL_P: begin
            mul_a = MA_W'(verr_ff);
            mul_b = $signed({7'b0, vel_kp_ff});
         end
         ST_VMUL_I: begin
            mul_a = MA_W'(verr_ff);
            mul_b = $signed({7'b0, vel_ki_ff});
         end
         ST_VMUL_D: begin
            mul_a = MA_W'(vel_diff);
            mul_b = $signed({7'b0, vel_kd_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Windowed, clamped integral.
   logic               i_window;
   logic signed [41:0] isum, ilim;
   logic signed [INT_W-1:0] itot_next;

   assign i_window = (averr_ff > VERR_W'(vel_i_window_ff[15:0])) &&
                     (averr_ff < VERR_W'(vel_i_window_ff[31:16]));
   assign isum = 42'(integ_ff[slot]) + (i_window ? 42'(i_ff) : 42'sd0);
   assign ilim = $signed({18'b0, vel_limits_ff[15:0], 8'b0});

   always_comb begin
      if (isum > ilim) begin
         itot_next = INT_W'(ilim);
      end else if (isum < -ilim) begin
         itot_next = INT_W'(-ilim);
      end else begin
         itot_next = INT_W'(isum);
      end
   end

   // Drive sum and clamp.
   logic signed [42:0] dsum, olim;
   logic signed [24:0] drv_next;

   assign dsum = 43'(p_ff) + 43'(d_ff) + 43'(itot_ff);
   assign olim = $signed({19'b0, vel_limits_ff[31:16], 8'b0});

   always_comb begin
      if (dsum > olim) begin
         drv_next = 25'(olim);
      end else if (dsum < -olim) begin
         drv_next = 25'(-olim);
      end else begin
         drv_next = 25'(dsum);
      end
   end

   // Truncation toward zero to whole units, then 16-bit saturation.
   logic signed [25:0] drv_adj;
   logic signed [17:0] drv_whole;
   logic [DRV_W-1:0]   drive_out;

   assign drv_adj   = 26'(drv_ff) + ((drv_ff < 0) ? 26'sd255 : 26'sd0);
   assign drv_whole = drv_adj[25:8];

   always_comb begin
      if (drv_whole > 18'sd32767) begin
         drive_out = 16'h7FFF;
      end else if (drv_whole < -18'sd32768) begin
         drive_out = 16'h8000;
      end else begin
         drive_out = drv_whole[15:0];
      end
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_MOTORS; k++) begin
            multi_ff[k]    <= '0;
            prev_ang_ff[k] <= '0;
            prev_vel_ff[k] <= '0;
            integ_ff[k]    <= '0;
         end
      end else begin
         // Output register: load a finished item, clear once it is taken.
         if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ch_ff   <= req_tuser;
                  raw_ff  <= req_tdata[12:0];
                  vel_ff  <= req_tdata[28:13];
                  tgt_ff  <= req_tdata[52:29];
                  cand_ff <= CAND_W'($signed(req_tdata[52:29]));
                  off_ff  <= '0;
                  step_ff <= '0;
                  last_ff <= 1'b0;
                  drv_ff  <= '0;
                  state_ff <= in_range ? ST_ALIAS : ST_FIN;
               end
            end
            ST_ALIAS: begin
               if (alias_near) begin
                  state_ff <= ST_TRACK;
               end else begin
                  cand_ff <= cand_next;
                  last_ff <= step_ff[0];
                  if (step_ff == STEP_W'(ALIAS_STEPS - 1)) begin
                     state_ff <= ST_TRACK;
                  end else begin
                     step_ff <= step_ff + STEP_W'(1);
                     off_ff  <= off_ff + OFF_W'(HALF_TURN);
                  end
               end
            end
            ST_TRACK: begin
               multi_ff[slot]    <= multi_new;
               prev_ang_ff[slot] <= deg;
               state_ff          <= ST_ERR;
            end
            ST_ERR: begin
               err_ff   <= DIFF_W'(cand_ff) - DIFF_W'(multi_cur);
               aerr_ff  <= (DIFF_W'(cand_ff) < DIFF_W'(multi_cur)) ?
                           DIFF_W'(DIFF_W'(multi_cur) - DIFF_W'(cand_ff)) :
                           DIFF_W'(DIFF_W'(cand_ff) - DIFF_W'(multi_cur));
               state_ff <= ST_PMUL;
            end
            ST_PMUL: begin
               state_ff <= ST_PNOW;
            end
            ST_PNOW: begin
               pnow_ff  <= prod[PNOW_W+7:8];
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               neg_ff <= pnow_ff < 0;
               if (!in_zone) begin
                  spd_raw_ff <= pnow_ff;
                  state_ff   <= ST_CLAMP;
               end else begin
                  state_ff <= ST_SMUL;
               end
            end
            ST_SMUL: begin
               // The gain floor is done here; the ramp goes on to the divider.
               if (gain_floor) begin
                  spd_raw_ff <= neg_ff ? -PNOW_W'(fifth_q) : PNOW_W'(fifth_q);
                  state_ff   <= ST_CLAMP;
               end else begin
                  neg_ff   <= prod < 0;
                  state_ff <= ST_SDIV;
               end
            end
            ST_SDIV: begin
               if (div_stat.done) begin
                  spd_raw_ff <= neg_ff ? -PNOW_W'(div_quotient)
                                       : PNOW_W'(div_quotient);
                  state_ff   <= ST_CLAMP;
               end
            end
            ST_CLAMP: begin
               spd_ff   <= spd_next;
               state_ff <= ST_VERR;
            end
            ST_VERR: begin
               verr_ff  <= verr_next;
               state_ff <= ST_VMUL_P;
            end
            ST_VMUL_P: begin
               averr_ff <= (verr_ff < 0) ? VERR_W'(-verr_ff) : VERR_W'(verr_ff);
               state_ff <= ST_VMUL_I;
            end
            ST_VMUL_I: begin
               p_ff     <= prod[48:8];
               state_ff <= ST_VMUL_D;
            end
            ST_VMUL_D: begin
               i_ff     <= prod[48:8];
               state_ff <= ST_VCAP;
            end
            ST_VCAP: begin
               d_ff     <= prod[40:0];
               state_ff <= ST_INTEG;
            end
            ST_INTEG: begin
               itot_ff           <= itot_next;
               integ_ff[slot]    <= itot_next;
               prev_vel_ff[slot] <= vel_ff;
               state_ff          <= ST_DRIVE;
            end
            ST_DRIVE: begin
               drv_ff   <= drv_next;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_drive_ff <= drive_out;
                  rsp_rev_ff   <= last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_kp_ff        <= 24'd12800;
         angle_outlimit_ff  <= 23'd1280000;
         angle_slow_zone_ff <= 16'd3584;
         vel_kp_ff          <= 24'd16384;
         vel_ki_ff          <= 24'd512;
         vel_kd_ff          <= 24'd768;
         vel_i_window_ff    <= 32'd167772672;
         vel_limits_ff      <= 32'd1310721000;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ANGLE_KP:        angle_kp_ff        <= csr_wdata[23:0];
            REG_ANGLE_OUTLIMIT:  angle_outlimit_ff  <= csr_wdata[22:0];
            REG_ANGLE_SLOW_ZONE: angle_slow_zone_ff <= csr_wdata[15:0];
            REG_VEL_KP:          vel_kp_ff          <= csr_wdata[23:0];
            REG_VEL_KI:          vel_ki_ff          <= csr_wdata[23:0];
            REG_VEL_KD:          vel_kd_ff          <= csr_wdata[23:0];
            REG_VEL_I_WINDOW:    vel_i_window_ff    <= csr_wdata;
            REG_VEL_LIMITS:      vel_limits_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_rev_ff, rsp_drive_ff};

   cavp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   cavp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   // The sequencer leaves idle right after an accepted item.
   `CAVP_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, state_ff != ST_IDLE, "busy")
   // A divider result only arrives while the sequencer waits for it.
   `CAVP_ASSERT_IMP(a_div_done_wait, clock, reset, div_stat.done, state_ff == ST_SDIV, "div")
   // The alias search never runs past its last step.
   `CAVP_ASSERT_IMP(a_alias_range, clock, reset, state_ff == ST_ALIAS, step_ff < STEP_W'(ALIAS_STEPS), "step")
   // A finished item moves into the output register and frees the sequencer.
   `CAVP_ASSERT_NXT(a_fin_handoff, clock, reset, state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == ST_IDLE, "fin")

endmodule

`default_nettype wire

FILE: verif/tb_cascaded_angle_velocity_pid_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the cascaded angle/velocity PID unit
// Drives feedback/target items on the request stream, predicts the drive
// value and reverse flag of every item with a cycle-free model of the
// controller, and compares each response in order. Runs through several
// gain settings and idle/stall patterns on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cascaded_angle_velocity_pid_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cavp_pkg::*;

   localparam int NMOT = 3;
   localparam longint CYCLE_LIMIT = 4000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   int  send_idle_pct;
   int  recv_stall_pct;
   longint cycle_count = 0;

   typedef struct packed {
      logic [15:0] drive;
      logic        reverse;
   } drive_result_type;

   // Model of the controller: gains, per-channel state, expected results.
   class pid_scoreboard;
      longint  kp_angle, lim_angle, zone_angle;
      longint  kp_vel, ki_vel, kd_vel;
      logic [31:0] i_window, limits;
      longint  multi_q[NMOT];
      longint  prev_deg[NMOT];
      longint  prev_vel[NMOT];
      longint  integ[NMOT];
      drive_result_type pending[$];
      int      errors;

      function new();
         kp_angle = 12800; lim_angle = 1280000; zone_angle = 3584;
         kp_vel = 16384; ki_vel = 512; kd_vel = 768;
         i_window = 32'd167772672; limits = 32'd1310721000;
         for (int k = 0; k < NMOT; k++) begin
            multi_q[k] = 0; prev_deg[k] = 0; prev_vel[k] = 0; integ[k] = 0;
         end
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            REG_ANGLE_KP:        kp_angle = v[23:0];
            REG_ANGLE_OUTLIMIT:  lim_angle = v[22:0];
            REG_ANGLE_SLOW_ZONE: zone_angle = v[15:0];
            REG_VEL_KP:          kp_vel = v[23:0];
            REG_VEL_KI:          ki_vel = v[23:0];
            REG_VEL_KD:          kd_vel = v[23:0];
            REG_VEL_I_WINDOW:    i_window = v;
            REG_VEL_LIMITS:      limits = v;
            default: ;
         endcase
      endfunction

      static function longint clip(longint x, longint lo, longint hi);
         return x < lo ? lo : (x > hi ? hi : x);
      endfunction

      static function longint mag(longint x);
         return x < 0 ? -x : x;
      endfunction

      // Q8 product, rounded toward minus infinity.
      static function longint q8_mul(longint g, longint x);
         return (g * x) >>> 8;
      endfunction

      // Predict the result of one accepted item and update channel state.
      function void note_item(logic [1:0] ch, logic [12:0] raw,
                              logic signed [15:0] vel_in,
                              logic signed [23:0] tgt_in);
         drive_result_type r;
         longint vel, tgt, multi, cand, diff, err, aerr, pnow, spd;
         longint verr, averr, p, iterm, itot, ilim, d, drv, olim, deg;
         int last_i;
         vel = vel_in; tgt = tgt_in; last_i = 0;
         if (ch >= NMOT) begin
            r.drive = '0; r.reverse = 1'b0;
            pending.push_back(r);
            return;
         end
         deg = (longint'(raw) * 360) / 8192;
         multi = multi_q[ch];
         // Search the half-turn aliases of the target for one near the tracked angle.
         cand = tgt;
         for (int i = 0; i < ALIAS_STEPS; i++) begin
            if (mag(cand - multi) < NEAR_BAND) break;
            if (cand < multi) cand = tgt + longint'(HALF_TURN) * i;
            else cand = tgt - longint'(HALF_TURN) * i;
            last_i = i;
         end
         // Multi-turn tracking with wrap correction and saturation.
         diff = deg - prev_deg[ch];
         if (diff < -180) diff += 360;
         else if (diff > 180) diff -= 360;
         multi = clip(multi + diff * 256, -64'sd2147483648, 64'sd2147483647);
         multi_q[ch] = multi;
         prev_deg[ch] = deg;
         // Angle loop with gain ramp inside the slow zone.
         err = cand - multi;
         aerr = mag(err);
         pnow = q8_mul(kp_angle, err);
         if (aerr < zone_angle) begin
            if (aerr * 5 < zone_angle) spd = pnow / 5;
            else spd = pnow * aerr / zone_angle;
         end else spd = pnow;
         spd = clip(spd, -lim_angle, lim_angle);
         // Velocity loop.
         verr = spd - vel * 256;
         averr = mag(verr);
         p = q8_mul(kp_vel, verr);
         iterm = 0;
         if (averr > longint'(i_window[15:0]) && averr < longint'(i_window[31:16]))
            iterm = q8_mul(ki_vel, verr);
         ilim = longint'(limits[15:0]) * 256;
         itot = clip(integ[ch] + iterm, -ilim, ilim);
         integ[ch] = itot;
         d = kd_vel * (prev_vel[ch] - vel);
         prev_vel[ch] = vel;
         olim = longint'(limits[31:16]) * 256;
         drv = clip(p + d + itot, -olim, olim) / 256;
         drv = clip(drv, -32768, 32767);
         r.drive = drv[15:0];
         r.reverse = last_i[0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [23:0] data);
         drive_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, got drive %0d rev %0b", $time,
                     $signed(data[15:0]), data[16]);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data[15:0] !== want.drive)
            begin
               $display("%0t: drive mismatch, expected %0d actual %0d", $time,
                        $signed(want.drive), $signed(data[15:0]));
               errors++;
            end
         if (data[16] !== want.reverse) begin
            $display("%0t: reverse mismatch, expected %0b actual %0b", $time,
                     want.reverse, data[16]);
            errors++;
         end
      endfunction
   endclass

   pid_scoreboard sb;

   cascaded_angle_velocity_pid_unit #(.NUM_MOTORS(NMOT)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Response side: check accepted items, stall at random.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] ch, logic [12:0] raw,
                            logic [15:0] vel, logic [23:0] tgt);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = ch;
      req_tdata  = {3'b000, tgt, vel, raw};
      do @(posedge clock); while (!req_tready);
      sb.note_item(ch, raw, vel, tgt);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Wait until all results are back, then let the block settle.
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] v);
      csr_we = 1'b1; csr_index = idx; csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, v);
   endtask

   // Random item: mostly tracking-like moves, some wild values.
   task automatic send_random();
      logic [1:0] ch;
      logic [23:0] tgt;
      logic [15:0] vel;
      ch = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      if ($urandom_range(3) == 0) begin
         tgt = 24'($urandom); vel = 16'($urandom);
      end else begin
         tgt = 24'($signed($urandom_range(40000)) - 20000 +
                   $signed(sb.multi_q[ch < NMOT ? ch : 0]));
         vel = 16'($signed($urandom_range(600)) - 300);
      end
      send_item(ch, 13'($urandom), vel, tgt);
   endtask

   task automatic random_gains();
      write_csr(REG_ANGLE_KP, $urandom_range(40000));
      write_csr(REG_ANGLE_OUTLIMIT, $urandom_range(3000000));
      write_csr(REG_ANGLE_SLOW_ZONE, $urandom_range(8000));
      write_csr(REG_VEL_KP, $urandom_range(40000));
      write_csr(REG_VEL_KI, $urandom_range(2000));
      write_csr(REG_VEL_KD, $urandom_range(3000));
      write_csr(REG_VEL_I_WINDOW, {16'($urandom_range(65535)), 16'($urandom_range(2000))});
      write_csr(REG_VEL_LIMITS, $urandom);
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0; recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0; csr_index = REG_ANGLE_KP; csr_wdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, out-of-range channel, far aliases.
      send_item(2'd0, 13'd0, 16'h0000, 24'h000000);
      send_item(2'd0, 13'h1FFF, 16'h7FFF, 24'h7FFFFF);
      send_item(2'd1, 13'h1000, 16'h8000, 24'h800000);
      send_item(2'd2, 13'd4096, 16'd10, 24'd46080);
      send_item(2'd2, 13'd0, 16'hFFFF, 24'hFFFFFF);
      send_item(2'd3, 13'h1FFF, 16'h7FFF, 24'h7FFFFF);
      send_item(2'd1, 13'd100, 16'd0, 24'd500);
      send_item(2'd1, 13'd120, 16'd3, 24'd200);
      send_item(2'd0, 13'd2048, 16'hFF00, 24'd23040);
      send_item(2'd2, 13'd6000, 16'd5, 24'hF00000);
      drain();

      // Extremes: zero slow zone, maximal gains and large clamps.
      write_csr(REG_ANGLE_SLOW_ZONE, 32'd0);
      write_csr(REG_ANGLE_KP, 32'hFFFFFF);
      write_csr(REG_ANGLE_OUTLIMIT, 32'h7FFFFF);
      write_csr(REG_VEL_KP, 32'hFFFFFF);
      write_csr(REG_VEL_KI, 32'hFFFFFF);
      write_csr(REG_VEL_KD, 32'hFFFFFF);
      write_csr(REG_VEL_I_WINDOW, 32'hFFFF0000);
      write_csr(REG_VEL_LIMITS, 32'hFFFFFFFF);
      for (int n = 0; n < 10; n++) send_random();
      send_item(2'd1, 13'h1FFF, 16'h8000, 24'h7FFFFF);
      send_item(2'd1, 13'd0, 16'h7FFF, 24'h800000);
      drain();

      // Random phases with varying gains and idle patterns.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (ph == 4) begin
            write_csr(REG_ANGLE_KP, 32'd0);
            write_csr(REG_ANGLE_SLOW_ZONE, 32'hFFFF);
            write_csr(REG_VEL_LIMITS, 32'd0);
         end else if (ph != 0) random_gains();
         for (int n = 0; n < 220; n++) send_random();
         drain();
      end

      if (sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
